// ===== rtl/dstsw_pkg.sv =====
// Package for the daylight-saving switch: field widths, calendar constants,
// BCD decode, month offset table and mod-7 reduction. No dependencies.
`timescale 1ns / 1ps

package dstsw_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned YearW = 12;
  localparam int unsigned WdayW = 3;
  localparam int unsigned CentW = 5;

  localparam logic [YearW-1:0] YearBase    = 12'd2000;
  localparam logic [YearW-1:0] YearCentEnd = 12'd2100;
  localparam logic [CentW-1:0] CentPrev    = 5'd19;
  localparam logic [CentW-1:0] CentBase    = 5'd20;
  localparam logic [CentW-1:0] CentNext    = 5'd21;
  localparam logic [2:0]       QuadPrev    = 3'd4;
  localparam logic [2:0]       QuadBase    = 3'd5;

  localparam logic [ByteW-1:0] MonthJan = 8'd1;
  localparam logic [ByteW-1:0] MonthMar = 8'd3;
  localparam logic [ByteW-1:0] MonthNov = 8'd11;
  localparam logic [ByteW-1:0] MonthDec = 8'd12;

  localparam logic [ByteW-1:0] SwitchHour   = 8'd2;
  localparam logic [ByteW-1:0] MarFirstDay  = 8'd8;
  localparam logic [ByteW-1:0] MarLastDay   = 8'd14;
  localparam logic [ByteW-1:0] NovFirstDay  = 8'd1;
  localparam logic [ByteW-1:0] NovLastDay   = 8'd7;

  localparam logic [ByteW-1:0] HourDstStart = 8'h03;
  localparam logic [ByteW-1:0] HourDstEnd   = 8'h01;
  localparam logic [ByteW-1:0] HourNone     = 8'h00;

  localparam logic [WdayW-1:0] WdaySunday  = 3'd0;
  localparam logic [WdayW-1:0] WdayInvalid = 3'd7;

  // Raw register snapshot
  typedef struct packed {
    logic [ByteW-1:0] seconds_bcd;
    logic [ByteW-1:0] minutes_bcd;
    logic [ByteW-1:0] hours_bcd;
    logic [ByteW-1:0] date_bcd;
    logic [ByteW-1:0] month_bcd;
    logic [ByteW-1:0] year_bcd;
  } time_raw_t;

  // Decoded calendar facts handed to the switch logic
  typedef struct packed {
    logic             month_valid;
    logic             at_two;
    logic [ByteW-1:0] month;
    logic [ByteW-1:0] day;
    logic [WdayW-1:0] weekday;
  } cal_info_t;

  // One result
  typedef struct packed {
    logic             write_hour;
    logic [ByteW-1:0] new_hour_bcd;
    logic             dst_active;
    logic [WdayW-1:0] weekday;
  } result_t;

  // high nibble * 10 + low nibble, nibbles taken at face value (0..165)
  function automatic logic [ByteW-1:0] bcd_decode(input logic [ByteW-1:0] b);
    logic [ByteW-1:0] hi;
    logic [ByteW-1:0] lo;
    hi = {4'b0, b[7:4]};
    lo = {4'b0, b[3:0]};
    return (hi << 3) + (hi << 1) + lo;
  endfunction

  // Sakamoto month offsets, month 1..12
  function automatic logic [2:0] month_offset(input logic [3:0] m);
    logic [2:0] o;
    case (m)
      4'd1:    o = 3'd0;
      4'd2:    o = 3'd3;
      4'd3:    o = 3'd2;
      4'd4:    o = 3'd5;
      4'd5:    o = 3'd0;
      4'd6:    o = 3'd3;
      4'd7:    o = 3'd5;
      4'd8:    o = 3'd1;
      4'd9:    o = 3'd4;
      4'd10:   o = 3'd6;
      4'd11:   o = 3'd2;
      4'd12:   o = 3'd4;
      default: o = 3'd0;
    endcase
    return o;
  endfunction

  // 8 == 1 mod 7: fold octal digits, then one conditional subtract
  function automatic logic [2:0] mod7(input logic [YearW-1:0] v);
    logic [4:0] s1;
    logic [3:0] s2;
    logic [3:0] r;
    s1 = {2'b0, v[2:0]} + {2'b0, v[5:3]} + {2'b0, v[8:6]} + {2'b0, v[11:9]};
    s2 = {1'b0, s1[2:0]} + {2'b0, s1[4:3]};
    r  = (s2 >= 4'd7) ? s2 - 4'd7 : s2;
    return r[2:0];
  endfunction

endpackage

// ===== rtl/dstsw_in_if.sv =====
// Request channel carrying one raw time snapshot.
// Depends on dstsw_pkg for field widths.
`timescale 1ns / 1ps

interface dstsw_in_if
  import dstsw_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] seconds_bcd;
  logic [ByteW-1:0] minutes_bcd;
  logic [ByteW-1:0] hours_bcd;
  logic [ByteW-1:0] date_bcd;
  logic [ByteW-1:0] month_bcd;
  logic [ByteW-1:0] year_bcd;

  modport source (output valid, seconds_bcd, minutes_bcd, hours_bcd, date_bcd,
                  month_bcd, year_bcd, input ready);
  modport sink   (input valid, seconds_bcd, minutes_bcd, hours_bcd, date_bcd,
                  month_bcd, year_bcd, output ready);
endinterface

// ===== rtl/dstsw_out_if.sv =====
// Result channel carrying the hour rewrite order, flag and weekday.
// Depends on dstsw_pkg for field widths.
`timescale 1ns / 1ps

interface dstsw_out_if
  import dstsw_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic             write_hour;
  logic [ByteW-1:0] new_hour_bcd;
  logic             dst_active;
  logic [WdayW-1:0] weekday;

  modport source (output valid, write_hour, new_hour_bcd, dst_active, weekday,
                  input ready);
  modport sink   (input valid, write_hour, new_hour_bcd, dst_active, weekday,
                  output ready);
endinterface

// ===== rtl/dstsw_weekday.sv =====
// BCD decode of the snapshot and weekday by Sakamoto's method.
// Combinational; depends on dstsw_pkg.
`timescale 1ns / 1ps

module dstsw_weekday
  import dstsw_pkg::*;
(
  input  time_raw_t raw,
  output cal_info_t info
);

  logic [ByteW-1:0] sec_d, min_d, hour_d, day_d, month_d, year_d;
  logic             month_valid;
  logic             early;
  logic [YearW-1:0] y;
  logic [CentW-1:0] cent;
  logic [2:0]       quad;
  logic [YearW-1:0] sum;

  // decode all six bytes
  assign sec_d   = bcd_decode(raw.seconds_bcd);
  assign min_d   = bcd_decode(raw.minutes_bcd);
  assign hour_d  = bcd_decode(raw.hours_bcd);
  assign day_d   = bcd_decode(raw.date_bcd);
  assign month_d = bcd_decode(raw.month_bcd);
  assign year_d  = bcd_decode(raw.year_bcd);

  assign month_valid = (month_d >= MonthJan) && (month_d <= MonthDec);
  assign early       = (month_d < MonthMar);

  // y spans 1999..2165, so y/100 and y/400 reduce to range checks
  assign y = YearBase + {4'b0, year_d} - {{(YearW-1){1'b0}}, early};

  always_comb begin
    if (y < YearBase) begin
      cent = CentPrev;
      quad = QuadPrev;
    end else if (y >= YearCentEnd) begin
      cent = CentNext;
      quad = QuadBase;
    end else begin
      cent = CentBase;
      quad = QuadBase;
    end
  end

  assign sum = y + {2'b0, y[YearW-1:2]} - {7'b0, cent} + {9'b0, quad}
             + {9'b0, month_offset(month_d[3:0])} + {4'b0, day_d};

  always_comb begin
    info.month_valid = month_valid;
    info.at_two      = (hour_d == SwitchHour) && (min_d == '0) && (sec_d == '0);
    info.month       = month_d;
    info.day         = day_d;
    info.weekday     = month_valid ? mod7(sum) : WdayInvalid;
  end

endmodule

// ===== rtl/dstsw_switch.sv =====
// Summer-time flag and the hour rewrite decision.
// Depends on dstsw_pkg; flag advances with each item leaving the input stage.
`timescale 1ns / 1ps

module dstsw_switch
  import dstsw_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      advance,
  input  cal_info_t info,
  output result_t   res
);

  logic summer_time_flag;
  logic summer_time_flag_next;
  logic start_hit;
  logic end_hit;

  // second Sunday of March / first Sunday of November at 02:00:00
  always_comb begin
    start_hit = !summer_time_flag && info.month_valid && (info.month == MonthMar)
              && (info.weekday == WdaySunday) && info.at_two
              && (info.day inside {[MarFirstDay:MarLastDay]});
    end_hit   = summer_time_flag && info.month_valid && (info.month == MonthNov)
              && (info.weekday == WdaySunday) && info.at_two
              && (info.day inside {[NovFirstDay:NovLastDay]});
  end

  always_comb begin
    summer_time_flag_next = summer_time_flag;
    if (start_hit) begin
      summer_time_flag_next = 1'b1;
    end else if (end_hit) begin
      summer_time_flag_next = 1'b0;
    end
  end

  always_comb begin
    res.write_hour   = start_hit || end_hit;
    res.new_hour_bcd = start_hit ? HourDstStart : (end_hit ? HourDstEnd : HourNone);
    res.dst_active   = summer_time_flag_next;
    res.weekday      = info.weekday;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      summer_time_flag <= 1'b0;
    end else if (advance) begin
      summer_time_flag <= summer_time_flag_next;
    end
  end

endmodule

// ===== rtl/dst_switch_from_rtc_time_unit.sv =====
// US daylight-saving switch. Each request is one snapshot of the RTC time
// registers; each yields one result with the weekday (7 for a bad month), the
// summer-time flag after this snapshot, and an order to rewrite the hour to
// BCD 3 at 02:00:00 on the second Sunday of March or BCD 1 at 02:00:00 on the
// first Sunday of November. A request is registered, decoded combinationally and
// its result registered; one request per cycle is sustained while the result
// channel is ready. The flag resets to standard time and updates in request order.
// Depends on dstsw_pkg, dstsw_in_if, dstsw_out_if, dstsw_weekday, dstsw_switch.
`timescale 1ns / 1ps

module dst_switch_from_rtc_time_unit
  import dstsw_pkg::*;
(
  input logic        clk,
  input logic        rst,
  dstsw_in_if.sink   in_ch,
  dstsw_out_if.source out_ch
);

  logic      s1_valid;
  time_raw_t s1_raw;
  logic      out_valid;
  result_t   out_res;
  logic      advance;
  cal_info_t info;
  result_t   res;

  // move the input stage forward when the result register is free or drains
  assign advance     = s1_valid && (!out_valid || out_ch.ready);
  assign in_ch.ready = !s1_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_raw.seconds_bcd <= in_ch.seconds_bcd;
      s1_raw.minutes_bcd <= in_ch.minutes_bcd;
      s1_raw.hours_bcd   <= in_ch.hours_bcd;
      s1_raw.date_bcd    <= in_ch.date_bcd;
      s1_raw.month_bcd   <= in_ch.month_bcd;
      s1_raw.year_bcd    <= in_ch.year_bcd;
    end
  end

  dstsw_weekday u_weekday (
    .raw  (s1_raw),
    .info (info)
  );

  dstsw_switch u_switch (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .info    (info),
    .res     (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res;
    end
  end

  assign out_ch.valid        = out_valid;
  assign out_ch.write_hour   = out_res.write_hour;
  assign out_ch.new_hour_bcd = out_res.new_hour_bcd;
  assign out_ch.dst_active   = out_res.dst_active;
  assign out_ch.weekday      = out_res.weekday;

  // rewrite orders agree with the flag they leave behind
  a_write_matches_flag: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_res.write_hour) |->
      ((out_res.new_hour_bcd == HourDstStart && out_res.dst_active) ||
       (out_res.new_hour_bcd == HourDstEnd && !out_res.dst_active)))
    else $error("hour rewrite does not match summer-time flag");

  a_no_write_zero_hour: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_res.write_hour) |-> (out_res.new_hour_bcd == HourNone))
    else $error("new hour nonzero without rewrite order");

  a_bad_month_no_action: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_res.weekday == WdayInvalid) |-> !out_res.write_hour)
    else $error("rewrite ordered for an invalid month");

  // flag changes only through a rewrite order leaving the input stage
  a_flag_change_needs_write: assert property (@(posedge clk) disable iff (rst)
    (advance && (res.dst_active != u_switch.summer_time_flag)) |-> res.write_hour)
    else $error("summer-time flag changed without a rewrite order");

endmodule
